// ===== design/kps_pkg.sv =====
// ----------------------------------------------------------------------------
// kps_pkg: shared types and constants of the k-space phase ramp shift unit
// Field widths, fixed-point formats, CORDIC constants and the sideband record
// that travels beside the rotator pipeline.
// ----------------------------------------------------------------------------
package kps_pkg;

	// Field widths and fixed-point formats.
	localparam int COORD_BITS  = 16;
	localparam int DELTA_BITS  = 32;
	localparam int SAMPLE_BITS = 24;
	localparam int PHASE_BITS  = 12;
	localparam int COORD_FRAC  = 6;
	localparam int DELTA_FRAC  = 30;

	// Phase products keep only the fraction of a cycle.
	localparam int PHASE_FRAC_BITS = COORD_FRAC + DELTA_FRAC;
	localparam int PHASE_LSB       = PHASE_FRAC_BITS - PHASE_BITS;
	localparam int MUL_BITS        = COORD_BITS + DELTA_BITS;

	// Angle in turns scaled by 2^32; the two top bits select the quadrant.
	localparam int ANGLE_BITS      = 32;
	localparam int QUAD_ANGLE_BITS = ANGLE_BITS - 2;

	// CORDIC datapath.
	localparam int CORDIC_STEPS = 28;
	localparam int CORDIC_W     = 33;
	localparam int CORDIC_ZW    = 33;
	localparam logic signed [CORDIC_W-1:0] CORDIC_START = CORDIC_W'(652032874);

	localparam logic signed [CORDIC_ZW-1:0] CORDIC_ATAN [CORDIC_STEPS] = '{
		CORDIC_ZW'(536870912), CORDIC_ZW'(316933406), CORDIC_ZW'(167458907),
		CORDIC_ZW'(85004756),  CORDIC_ZW'(42667331),  CORDIC_ZW'(21354465),
		CORDIC_ZW'(10679838),  CORDIC_ZW'(5340245),   CORDIC_ZW'(2670163),
		CORDIC_ZW'(1335087),   CORDIC_ZW'(667544),    CORDIC_ZW'(333772),
		CORDIC_ZW'(166886),    CORDIC_ZW'(83443),     CORDIC_ZW'(41722),
		CORDIC_ZW'(20861),     CORDIC_ZW'(10430),     CORDIC_ZW'(5215),
		CORDIC_ZW'(2608),      CORDIC_ZW'(1304),      CORDIC_ZW'(652),
		CORDIC_ZW'(326),       CORDIC_ZW'(163),       CORDIC_ZW'(81),
		CORDIC_ZW'(41),        CORDIC_ZW'(20),        CORDIC_ZW'(10),
		CORDIC_ZW'(5)
	};

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELTA_X = 2'd0,
		REG_DELTA_Y = 2'd1,
		REG_DELTA_Z = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	typedef logic signed [COORD_BITS-1:0]  coord_t;
	typedef logic signed [DELTA_BITS-1:0]  delta_t;
	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	// Everything an item needs after the rotator besides the angle itself.
	typedef struct packed {
		logic    point_valid;
		quad_t   quad;
		sample_t re;
		sample_t im;
	} side_t;

endpackage

// ===== design/kps_in_if.sv =====
// ----------------------------------------------------------------------------
// kps_in_if: input sample channel
// Valid/ready channel carrying one trajectory point and its complex sample.
// ----------------------------------------------------------------------------
interface kps_in_if;
	logic             valid;
	logic             ready;
	kps_pkg::coord_t  coord_x;
	kps_pkg::coord_t  coord_y;
	kps_pkg::coord_t  coord_z;
	logic             point_valid;
	kps_pkg::sample_t sample_re;
	kps_pkg::sample_t sample_im;

	modport source (
		output valid, coord_x, coord_y, coord_z, point_valid, sample_re, sample_im,
		input  ready
	);

	modport sink (
		input  valid, coord_x, coord_y, coord_z, point_valid, sample_re, sample_im,
		output ready
	);
endinterface

// ===== design/kps_out_if.sv =====
// ----------------------------------------------------------------------------
// kps_out_if: shifted sample channel
// Valid/ready channel carrying one phase-rotated complex sample.
// ----------------------------------------------------------------------------
interface kps_out_if;
	logic             valid;
	logic             ready;
	kps_pkg::sample_t shifted_re;
	kps_pkg::sample_t shifted_im;

	modport source (
		output valid, shifted_re, shifted_im,
		input  ready
	);

	modport sink (
		input  valid, shifted_re, shifted_im,
		output ready
	);
endinterface

// ===== design/kspace_phase_ramp_shift_unit.sv =====
// ----------------------------------------------------------------------------
// kspace_phase_ramp_shift_unit: Fourier shift by a linear phase ramp
// Rotates each complex k-space sample by exp(+i*2*pi*phase), where the phase
// in cycles is the dot product of the trajectory point and the shift ratios.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake      Payload
//  -------   ---------  -------------  ---------------------------------------
//  sample    in         valid / ready  coord_x/y/z, point_valid, sample_re/im
//  result    out        valid / ready  shifted_re, shifted_im
//  cfg       in         cfg_we         cfg_index, cfg_wdata (write only)
//
// The unit takes one sample per clock and has 35 register stages between a
// transfer on sample and the first cycle its result is offered on result:
// two phase stages, 28 CORDIC micro-rotations, four rotate/round stages and
// the output register. The CORDIC chain sets the depth.
// Reset clears the shift ratios, all stage valid bits and the output buffer.
// A stall on result parks at most one result in a skid register; the whole
// pipeline then holds, and sample.ready stays low until the skid drains.
//
module kspace_phase_ramp_shift_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [kps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [kps_pkg::DELTA_BITS-1:0]     cfg_wdata,
	kps_in_if.sink                             sample,
	kps_out_if.source                          result
);

	localparam int SB      = kps_pkg::SAMPLE_BITS;
	localparam int PB      = kps_pkg::PHASE_BITS;
	localparam int PFB     = kps_pkg::PHASE_FRAC_BITS;
	localparam int CW      = kps_pkg::CORDIC_W;
	localparam int PROD_W  = SB + CW;
	localparam int ACC_W   = PROD_W + 1;
	localparam int R_W     = ACC_W - kps_pkg::DELTA_FRAC;

	localparam logic [PFB-1:0] PHASE_HALF = PFB'(64'd1 << (kps_pkg::PHASE_LSB - 1));
	localparam logic signed [ACC_W-1:0] ROUND_HALF =
		ACC_W'(64'd1 << (kps_pkg::DELTA_FRAC - 1));

	// ------------------------------------------------------------------------
	// Configuration registers. Writes to an index past the last register are
	// dropped.
	// ------------------------------------------------------------------------
	kps_pkg::delta_t delta_x_q, delta_y_q, delta_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delta_x_q <= '0;
			delta_y_q <= '0;
			delta_z_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				kps_pkg::REG_DELTA_X: delta_x_q <= cfg_wdata;
				kps_pkg::REG_DELTA_Y: delta_y_q <= cfg_wdata;
				kps_pkg::REG_DELTA_Z: delta_z_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Flow control. Every stage advances together while the skid register is
	// empty, so the input ready comes straight from a flop.
	// ------------------------------------------------------------------------
	logic pipe_en;
	logic skid_v_q;

	assign pipe_en      = !skid_v_q;
	assign sample.ready = pipe_en;

	// ------------------------------------------------------------------------
	// Stage 1: one coordinate-by-ratio product per axis. Only the fraction of
	// a cycle is kept, so each product is cut to its low fraction bits.
	// ------------------------------------------------------------------------
	logic signed [kps_pkg::MUL_BITS-1:0] mul_x, mul_y, mul_z;
	logic                   v_s1;
	logic [PFB-1:0]         prod_x_s1, prod_y_s1, prod_z_s1;
	logic                   pv_s1;
	kps_pkg::sample_t       re_s1, im_s1;

	always_comb begin
		mul_x = sample.coord_x * delta_x_q;
		mul_y = sample.coord_y * delta_y_q;
		mul_z = sample.coord_z * delta_z_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pipe_en) begin
			v_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			prod_x_s1 <= mul_x[PFB-1:0];
			prod_y_s1 <= mul_y[PFB-1:0];
			prod_z_s1 <= mul_z[PFB-1:0];
			pv_s1     <= sample.point_valid;
			re_s1     <= sample.sample_re;
			im_s1     <= sample.sample_im;
		end
	end

	// ------------------------------------------------------------------------
	// Stage 2: sum the three products modulo one cycle and round half up to
	// the table index width. The index wraps, so a phase just below a whole
	// cycle rounds to index zero.
	// ------------------------------------------------------------------------
	logic [PFB-1:0]    phase_sum;
	logic              v_s2;
	logic [PB-1:0]     k_s2;
	kps_pkg::side_t    side_s2;

	assign phase_sum = prod_x_s1 + prod_y_s1 + prod_z_s1 + PHASE_HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (pipe_en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			k_s2                <= phase_sum[PFB-1:kps_pkg::PHASE_LSB];
			side_s2.point_valid <= pv_s1;
			side_s2.quad        <= kps_pkg::quad_t'(phase_sum[PFB-1:PFB-2]);
			side_s2.re          <= re_s1;
			side_s2.im          <= im_s1;
		end
	end

	// ------------------------------------------------------------------------
	// CORDIC: cosine and sine of the angle within its quadrant. The index is
	// placed at the top of a 32-bit turn count; the quadrant bits were already
	// split off into the sideband.
	// ------------------------------------------------------------------------
	logic [kps_pkg::QUAD_ANGLE_BITS-1:0] quad_angle;
	logic                   cor_v;
	logic signed [CW-1:0]   cor_cos, cor_sin;
	kps_pkg::side_t         cor_side;

	assign quad_angle = {k_s2[PB-3:0], {(kps_pkg::ANGLE_BITS - PB){1'b0}}};

	kps_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (v_s2),
		.in_angle  (quad_angle),
		.in_side   (side_s2),
		.out_valid (cor_v),
		.out_cos   (cor_cos),
		.out_sin   (cor_sin),
		.out_side  (cor_side)
	);

	// ------------------------------------------------------------------------
	// Stage 3: fold the first-quadrant result out to the full circle.
	// ------------------------------------------------------------------------
	logic signed [CW-1:0]   cos_q, sin_q;
	logic                   v_s3;
	logic signed [CW-1:0]   cos_s3, sin_s3;
	kps_pkg::side_t         side_s3;

	always_comb begin
		case (cor_side.quad)
			kps_pkg::QUAD_0: begin
				cos_q = cor_cos;
				sin_q = cor_sin;
			end
			kps_pkg::QUAD_1: begin
				cos_q = -cor_sin;
				sin_q = cor_cos;
			end
			kps_pkg::QUAD_2: begin
				cos_q = -cor_cos;
				sin_q = -cor_sin;
			end
			default: begin
				cos_q = cor_sin;
				sin_q = -cor_cos;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (pipe_en) begin
			v_s3 <= cor_v;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			cos_s3  <= cos_q;
			sin_s3  <= sin_q;
			side_s3 <= cor_side;
		end
	end

	// ------------------------------------------------------------------------
	// Stage 4: the four products of the complex rotation.
	// ------------------------------------------------------------------------
	logic signed [PROD_W-1:0] mul_rc, mul_is, mul_rs, mul_ic;
	logic                     v_s4;
	logic signed [PROD_W-1:0] rc_s4, is_s4, rs_s4, ic_s4;
	logic                     pv_s4;

	always_comb begin
		mul_rc = side_s3.re * cos_s3;
		mul_is = side_s3.im * sin_s3;
		mul_rs = side_s3.re * sin_s3;
		mul_ic = side_s3.im * cos_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (pipe_en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			rc_s4 <= mul_rc;
			is_s4 <= mul_is;
			rs_s4 <= mul_rs;
			ic_s4 <= mul_ic;
			pv_s4 <= side_s3.point_valid;
		end
	end

	// ------------------------------------------------------------------------
	// Stage 5: combine the products and add half an LSB of the output scale.
	// ------------------------------------------------------------------------
	logic                    v_s5;
	logic signed [ACC_W-1:0] acc_re_s5, acc_im_s5;
	logic                    pv_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (pipe_en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			acc_re_s5 <= ACC_W'(rc_s4) - ACC_W'(is_s4) + ROUND_HALF;
			acc_im_s5 <= ACC_W'(rs_s4) + ACC_W'(ic_s4) + ROUND_HALF;
			pv_s5     <= pv_s4;
		end
	end

	// ------------------------------------------------------------------------
	// Stage 6: drop the table scale, saturate to the sample width, and force
	// zero for a discarded trajectory point.
	// ------------------------------------------------------------------------
	function automatic kps_pkg::sample_t round_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] shifted;
		logic [R_W-1:0]          r;
		logic                    fits;
		shifted = acc >>> kps_pkg::DELTA_FRAC;
		r       = shifted[R_W-1:0];
		fits    = (&r[R_W-1:SB-1]) || !(|r[R_W-1:SB-1]);
		if (fits) begin
			round_sat = r[SB-1:0];
		end else if (r[R_W-1]) begin
			round_sat = {1'b1, {(SB-1){1'b0}}};
		end else begin
			round_sat = {1'b0, {(SB-1){1'b1}}};
		end
	endfunction

	logic             v_s6;
	kps_pkg::sample_t re_s6, im_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (pipe_en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			re_s6 <= pv_s5 ? round_sat(acc_re_s5) : '0;
			im_s6 <= pv_s5 ? round_sat(acc_im_s5) : '0;
		end
	end

	// ------------------------------------------------------------------------
	// Output register with one skid entry. A result leaves stage 6 whenever
	// the pipeline advances; if the output register is still occupied and
	// not being taken, it lands in the skid register instead, which halts the
	// pipeline from the next cycle on.
	// ------------------------------------------------------------------------
	logic             out_v_q;
	kps_pkg::sample_t out_re_q, out_im_q;
	kps_pkg::sample_t skid_re_q, skid_im_q;
	logic             push;
	logic             take;

	assign push = pipe_en && v_s6;
	assign take = out_v_q && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) begin
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || take) begin
			out_v_q <= push;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				out_re_q <= skid_re_q;
				out_im_q <= skid_im_q;
			end
		end else if (!out_v_q || take) begin
			out_re_q <= re_s6;
			out_im_q <= im_s6;
		end else if (push) begin
			skid_re_q <= re_s6;
			skid_im_q <= im_s6;
		end
	end

	assign result.valid      = out_v_q;
	assign result.shifted_re = out_re_q;
	assign result.shifted_im = out_im_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------

	// The skid entry is only ever filled behind an occupied output register.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register holds a result while the output is empty");

	// A halted pipeline keeps its items in place.
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!pipe_en && v_s2) |=> (v_s2 && $stable(k_s2)))
		else $error("phase index changed while the pipeline was halted");

	// A discarded point leaves the rounding stage as zero.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(pipe_en && v_s5 && !pv_s5) |=> (re_s6 == '0 && im_s6 == '0))
		else $error("discarded point produced a nonzero result");

endmodule

// ===== design/kps_cordic.sv =====
// ----------------------------------------------------------------------------
// kps_cordic: pipelined rotation-mode CORDIC
// One micro-rotation per register stage, producing cosine and sine of an
// angle within the first quadrant; the sideband record rides along.
// ----------------------------------------------------------------------------
module kps_cordic (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_valid,
	input  logic [kps_pkg::QUAD_ANGLE_BITS-1:0]    in_angle,
	input  kps_pkg::side_t                         in_side,
	output logic                                   out_valid,
	output logic signed [kps_pkg::CORDIC_W-1:0]    out_cos,
	output logic signed [kps_pkg::CORDIC_W-1:0]    out_sin,
	output kps_pkg::side_t                         out_side
);

	localparam int STEPS = kps_pkg::CORDIC_STEPS;
	localparam int CW    = kps_pkg::CORDIC_W;
	localparam int ZW    = kps_pkg::CORDIC_ZW;

	logic                  v_s    [0:STEPS];
	logic signed [CW-1:0]  x_s    [0:STEPS];
	logic signed [CW-1:0]  y_s    [0:STEPS];
	logic signed [ZW-1:0]  z_s    [0:STEPS];
	kps_pkg::side_t        side_s [0:STEPS];

	// Stage zero is the unregistered entry point of the chain.
	assign v_s[0]    = in_valid;
	assign x_s[0]    = kps_pkg::CORDIC_START;
	assign y_s[0]    = '0;
	assign z_s[0]    = signed'({{(ZW-kps_pkg::QUAD_ANGLE_BITS){1'b0}}, in_angle});
	assign side_s[0] = in_side;

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		// Rotate toward the residual angle; shifts round toward minus infinity.
		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i+1] <= side_s[i];
				if (!z_s[i][ZW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - kps_pkg::CORDIC_ATAN[i];
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + kps_pkg::CORDIC_ATAN[i];
				end
			end
		end
	end

	assign out_valid = v_s[STEPS];
	assign out_cos   = x_s[STEPS];
	assign out_sin   = y_s[STEPS];
	assign out_side  = side_s[STEPS];

endmodule
